// ===== rtl/core/dda_pkg.sv =====
// Shared types and constants of the DDA line rasterizer.
package dda_pkg;

  localparam int unsigned CoordW    = 6;
  localparam int unsigned PitchW    = 13;
  localparam int unsigned AddrW     = 18;
  localparam int unsigned InDataW   = 24;
  localparam int unsigned OutDataW  = 32;

  localparam logic [CoordW-1:0] CoordMax = 6'd63;
  localparam logic [PitchW-1:0] PitchMax = 13'd4096;
  localparam logic [PitchW-1:0] PitchRst = 13'd64;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SETUP,
    ST_RUN
  } state_e;

  typedef struct packed {
    logic load;
    logic setup;
    logic step;
  } cmd_t;

  typedef struct packed {
    logic out_free;
    logic at_end;
  } status_t;

  function automatic logic [CoordW-1:0] sat_coord(input logic [CoordW-1:0] c);
    sat_coord = (c > CoordMax) ? CoordMax : c;
  endfunction

endpackage

// ===== rtl/core/dda_ctrl.sv =====
// Controller state machine that sequences load, setup and pixel stepping.
module dda_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  dda_pkg::status_t sts_i,
  output dda_pkg::cmd_t    cmd_o
);

  dda_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= dda_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d       = state_q;
    cmd_o         = '0;
    s_axis_tready = 1'b0;
    case (state_q)
      dda_pkg::ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          cmd_o.load = 1'b1;
          state_d    = dda_pkg::ST_SETUP;
        end
      end
      dda_pkg::ST_SETUP: begin
        cmd_o.setup = 1'b1;
        state_d     = dda_pkg::ST_RUN;
      end
      dda_pkg::ST_RUN: begin
        if (sts_i.out_free) begin
          cmd_o.step = 1'b1;
          if (sts_i.at_end) begin
            state_d = dda_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_d = dda_pkg::ST_IDLE;
      end
    endcase
  end

  a_step_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == dda_pkg::ST_RUN && sts_i.out_free) |-> cmd_o.step)
    else $error("Pixel step withheld although the output register is free.");

  a_accept_only_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> (state_q == dda_pkg::ST_IDLE && !cmd_o.step))
    else $error("Segment accepted while a segment is in progress.");

  a_end_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.step && sts_i.at_end) |=> (state_q == dda_pkg::ST_IDLE))
    else $error("Controller did not return to idle after the final pixel.");

  a_load_to_setup: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> (state_q == dda_pkg::ST_SETUP))
    else $error("Setup did not follow a segment load.");

endmodule

// ===== rtl/core/dda_datapath.sv =====
// Datapath with segment registers, exact step accumulators and the output register.
module dda_datapath (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic [dda_pkg::InDataW-1:0]    s_axis_tdata,
  input  logic                           cfg_valid_i,
  input  logic [dda_pkg::PitchW-1:0]     cfg_data_i,
  input  dda_pkg::cmd_t                  cmd_i,
  output dda_pkg::status_t               sts_o,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [dda_pkg::OutDataW-1:0]   m_axis_tdata,
  output logic                           m_axis_tlast
);

  localparam int unsigned CW = dda_pkg::CoordW;
  localparam int unsigned PW = dda_pkg::PitchW;
  localparam int unsigned AW = dda_pkg::AddrW;

  logic [PW-1:0] pitch_q;
  logic [CW-1:0] sx_q, sy_q, ex_q, ey_q;
  logic [CW-1:0] adx_q, ady_q, n_q, k_q;
  logic          negx_q, negy_q;
  logic [CW-1:0] qx_q, rx_q, qy_q, ry_q;

  logic          out_valid_q;
  logic [AW-1:0] out_addr_q;
  logic [CW-1:0] out_x_q, out_y_q;
  logic          out_last_q;

  logic [CW-1:0] adx_c, ady_c, n_c;
  logic [CW:0]   rx_sum, ry_sum;
  logic [CW-1:0] px_c, py_c;
  logic [PW-1:0] pitch_eff;
  logic [AW:0]   prod_c;
  logic [AW-1:0] addr_c;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pitch_q <= dda_pkg::PitchRst;
    end else if (cfg_valid_i) begin
      pitch_q <= cfg_data_i;
    end
  end

  assign adx_c = (ex_q >= sx_q) ? (ex_q - sx_q) : (sx_q - ex_q);
  assign ady_c = (ey_q >= sy_q) ? (ey_q - sy_q) : (sy_q - ey_q);
  assign n_c   = (adx_c > ady_c) ? adx_c : ady_c;

  assign rx_sum = {1'b0, rx_q} + {1'b0, adx_q};
  assign ry_sum = {1'b0, ry_q} + {1'b0, ady_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      sx_q <= dda_pkg::sat_coord(s_axis_tdata[5:0]);
      sy_q <= dda_pkg::sat_coord(s_axis_tdata[11:6]);
      ex_q <= dda_pkg::sat_coord(s_axis_tdata[17:12]);
      ey_q <= dda_pkg::sat_coord(s_axis_tdata[23:18]);
    end
    if (cmd_i.setup) begin
      adx_q  <= adx_c;
      ady_q  <= ady_c;
      n_q    <= n_c;
      k_q    <= '0;
      negx_q <= ex_q < sx_q;
      negy_q <= ey_q < sy_q;
      qx_q   <= '0;
      qy_q   <= '0;
      // Rounding toward minus infinity on a falling axis takes the ceiling of k*mag/n.
      rx_q   <= ((ex_q < sx_q) && (n_c != '0)) ? (n_c - 1'b1) : '0;
      ry_q   <= ((ey_q < sy_q) && (n_c != '0)) ? (n_c - 1'b1) : '0;
    end else if (cmd_i.step) begin
      k_q <= k_q + 1'b1;
      if (rx_sum >= {1'b0, n_q}) begin
        rx_q <= CW'(rx_sum - {1'b0, n_q});
        qx_q <= qx_q + 1'b1;
      end else begin
        rx_q <= CW'(rx_sum);
      end
      if (ry_sum >= {1'b0, n_q}) begin
        ry_q <= CW'(ry_sum - {1'b0, n_q});
        qy_q <= qy_q + 1'b1;
      end else begin
        ry_q <= CW'(ry_sum);
      end
    end
  end

  assign px_c      = negx_q ? (sx_q - qx_q) : (sx_q + qx_q);
  assign py_c      = negy_q ? (sy_q - qy_q) : (sy_q + qy_q);
  assign pitch_eff = (pitch_q > dda_pkg::PitchMax) ? dda_pkg::PitchMax : pitch_q;
  assign prod_c    = (AW+1)'(py_c) * (AW+1)'(pitch_eff);
  assign addr_c    = AW'(prod_c + (AW+1)'(px_c));

  assign sts_o.out_free = !out_valid_q || m_axis_tready;
  assign sts_o.at_end   = (k_q == n_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.step) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.step) begin
      out_addr_q <= addr_c;
      out_x_q    <= px_c;
      out_y_q    <= py_c;
      out_last_q <= (k_q == n_q);
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {2'b00, out_y_q, out_x_q, out_addr_q};
  assign m_axis_tlast  = out_last_q;

endmodule

// ===== rtl/core/dda_line_rasterizer_core.sv =====
// Top level of the DDA line rasterizer: controller and datapath.
//
// A segment arrives as one transaction on the s_axis channel and leaves as
// one transaction per pixel on the m_axis channel, from start to end, with
// m_axis_tlast high on the final pixel. A segment of n steps, n being the
// larger of the column and row distances, yields n + 1 pixels.
// The row pitch used for the frame buffer word address is written through
// the cfg channel, which is always ready; write it only while no segment
// is in progress. Pitches above 4096 act as 4096.
// The accepting cycle loads the segment and the next cycle sets up the step
// counters; pixels then leave at one per cycle while the receiver keeps
// m_axis_tready high, each passing through the output register.
// The sequencing controller handles one segment at a time, and s_axis_tready
// is high again in the cycle after the final pixel enters the output register.
// When the receiver holds m_axis_tready low, the output register keeps its
// pixel and stepping pauses until it drains.
// Reset empties the output register, returns the controller to idle and sets
// the row pitch to 64.
module dda_line_rasterizer_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,  // start_x, start_y, end_x, end_y
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,  // pixel_address, pixel_x, pixel_y, zero fill
  output logic        m_axis_tlast,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [12:0] cfg_data_i     // row_pitch
);

  dda_pkg::cmd_t    cmd;
  dda_pkg::status_t sts;

  assign cfg_ready_o = 1'b1;

  dda_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .sts_i         (sts),
    .cmd_o         (cmd)
  );

  dda_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tdata  (s_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_data_i    (cfg_data_i),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

// ===== test/dda_line_rasterizer_core_test.sv =====
// Self-checking testbench of the DDA line rasterizer core with its own pixel predictor.
`timescale 1ns / 1ps

module dda_line_rasterizer_core_test;

  typedef struct packed {
    logic [5:0] sx;
    logic [5:0] sy;
    logic [5:0] ex;
    logic [5:0] ey;
  } segment_t;

  typedef struct packed {
    logic [17:0] addr;
    logic [5:0]  x;
    logic [5:0]  y;
    logic        last;
  } pixel_t;

  typedef struct packed {
    logic        set_pitch;
    logic [12:0] pitch;
    segment_t    seg;
    logic        fixed;
    pixel_t      pix;
  } stim_row_t;

  localparam int unsigned NumRows = 21;
  localparam int unsigned NumPhases = 6;
  localparam int unsigned ItemsPerPhase = 25;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;
  logic        m_axis_tlast;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [12:0] cfg_data_i;

  pixel_t      pending_pixels[$];
  logic [12:0] row_pitch_q = dda_pkg::PitchRst;
  int unsigned mismatch_count = 0;
  int unsigned tx_gap_pct = 24;
  int unsigned rx_stall_pct = 51;

  stim_row_t directed_rows [NumRows] = '{
    '{1'b0, 13'd0, '{6'd0, 6'd0, 6'd0, 6'd0}, 1'b1, '{18'd0, 6'd0, 6'd0, 1'b1}},
    '{1'b0, 13'd0, '{6'd63, 6'd63, 6'd63, 6'd63}, 1'b1, '{18'd4095, 6'd63, 6'd63, 1'b1}},
    '{1'b0, 13'd0, '{6'd0, 6'd0, 6'd63, 6'd63}, 1'b0, '0},
    '{1'b0, 13'd0, '{6'd63, 6'd0, 6'd0, 6'd63}, 1'b0, '0},
    '{1'b0, 13'd0, '{6'd0, 6'd63, 6'd63, 6'd0}, 1'b0, '0},
    '{1'b0, 13'd0, '{6'd63, 6'd63, 6'd0, 6'd0}, 1'b0, '0},
    '{1'b0, 13'd0, '{6'd0, 6'd5, 6'd63, 6'd5}, 1'b0, '0},
    '{1'b0, 13'd0, '{6'd10, 6'd63, 6'd10, 6'd0}, 1'b0, '0},
    '{1'b0, 13'd0, '{6'd0, 6'd0, 6'd63, 6'd1}, 1'b0, '0},
    '{1'b0, 13'd0, '{6'd5, 6'd0, 6'd0, 6'd63}, 1'b0, '0},
    '{1'b0, 13'd0, '{6'd1, 6'd2, 6'd2, 6'd1}, 1'b0, '0},
    '{1'b0, 13'd0, '{6'd40, 6'd20, 6'd37, 6'd29}, 1'b0, '0},
    '{1'b1, 13'd0, '{6'd63, 6'd63, 6'd63, 6'd63}, 1'b1, '{18'd63, 6'd63, 6'd63, 1'b1}},
    '{1'b0, 13'd0, '{6'd0, 6'd0, 6'd63, 6'd20}, 1'b0, '0},
    '{1'b1, 13'd1, '{6'd63, 6'd63, 6'd63, 6'd63}, 1'b1, '{18'd126, 6'd63, 6'd63, 1'b1}},
    '{1'b1, 13'd4096, '{6'd63, 6'd63, 6'd63, 6'd63}, 1'b1,
      '{18'd258111, 6'd63, 6'd63, 1'b1}},
    '{1'b0, 13'd0, '{6'd0, 6'd63, 6'd63, 6'd0}, 1'b0, '0},
    '{1'b1, 13'd8191, '{6'd63, 6'd63, 6'd63, 6'd63}, 1'b1,
      '{18'd258111, 6'd63, 6'd63, 1'b1}},
    '{1'b0, 13'd0, '{6'd0, 6'd0, 6'd0, 6'd63}, 1'b0, '0},
    '{1'b1, 13'd4097, '{6'd1, 6'd1, 6'd1, 6'd1}, 1'b1, '{18'd4097, 6'd1, 6'd1, 1'b1}},
    '{1'b1, 13'd1000, '{6'd3, 6'd60, 6'd50, 6'd7}, 1'b0, '0}
  };

  dda_line_rasterizer_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Position along one axis: start plus the signed share of the distance, floored.
  function automatic logic [5:0] axis_position(input int unsigned from, input int unsigned to,
                                               input int unsigned k, input int unsigned n);
    int unsigned mag;
    if (n == 0) begin
      return 6'(from);
    end
    if (to >= from) begin
      mag = to - from;
      return 6'(from + (k * mag) / n);
    end
    mag = from - to;
    return 6'(from - (k * mag + n - 1) / n);
  endfunction

  task automatic rasterize_segment(input segment_t seg);
    int unsigned dx;
    int unsigned dy;
    int unsigned n;
    int unsigned pitch;
    int unsigned addr;
    pixel_t pix;
    dx = (seg.ex >= seg.sx) ? seg.ex - seg.sx : seg.sx - seg.ex;
    dy = (seg.ey >= seg.sy) ? seg.ey - seg.sy : seg.sy - seg.ey;
    n = (dx > dy) ? dx : dy;
    pitch = (row_pitch_q > dda_pkg::PitchMax) ? dda_pkg::PitchMax : row_pitch_q;
    for (int unsigned k = 0; k <= n; k++) begin
      pix.x = axis_position(seg.sx, seg.ex, k, n);
      pix.y = axis_position(seg.sy, seg.ey, k, n);
      addr = pix.y * pitch + pix.x;
      pix.addr = addr[17:0];
      pix.last = (k == n);
      pending_pixels.push_back(pix);
    end
  endtask

  task automatic send_segment(input segment_t seg, input logic fixed, input pixel_t pix);
    while ($urandom_range(0, 99) < tx_gap_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {seg.ey, seg.ex, seg.sy, seg.sx};
    do @(posedge clk_i); while (!s_axis_tready);
    if (fixed) begin
      pending_pixels.push_back(pix);
    end else begin
      rasterize_segment(seg);
    end
  endtask

  task automatic drain_pixels();
    s_axis_tvalid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_pitch(input logic [12:0] value);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    row_pitch_q = value;
  endtask

  function automatic segment_t random_segment();
    segment_t seg;
    int unsigned pick;
    int unsigned len;
    logic [5:0] tmp;
    pick = $urandom_range(0, 99);
    seg.sx = 6'($urandom_range(0, 63));
    seg.sy = 6'($urandom_range(0, 63));
    seg.ex = 6'($urandom_range(0, 63));
    seg.ey = 6'($urandom_range(0, 63));
    if (pick >= 55 && pick < 65) begin
      seg.ey = seg.sy;
    end else if (pick >= 65 && pick < 75) begin
      seg.ex = seg.sx;
    end else if (pick >= 75 && pick < 85) begin
      len = (seg.ex >= seg.sx) ? seg.ex - seg.sx : seg.sx - seg.ex;
      seg.sy = 6'($urandom_range(0, 63 - len));
      seg.ey = 6'(seg.sy + len);
      if ($urandom_range(0, 1) == 1) begin
        tmp = seg.sy;
        seg.sy = seg.ey;
        seg.ey = tmp;
      end
    end else if (pick >= 85 && pick < 93) begin
      seg.ex = seg.sx;
      seg.ey = seg.sy;
    end else if (pick >= 93) begin
      seg.sx = $urandom_range(0, 1) ? 6'd63 : 6'd0;
      seg.sy = $urandom_range(0, 1) ? 6'd63 : 6'd0;
      seg.ex = $urandom_range(0, 1) ? 6'd63 : 6'd0;
      seg.ey = $urandom_range(0, 1) ? 6'd63 : 6'd0;
    end
    return seg;
  endfunction

  always @(posedge clk_i) begin : receive_pixels
    pixel_t got;
    pixel_t want;
    if (m_axis_tvalid && m_axis_tready) begin
      got = '{m_axis_tdata[17:0], m_axis_tdata[23:18], m_axis_tdata[29:24], m_axis_tlast};
      if (pending_pixels.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) begin
          $display("unexpected pixel: addr %0d x %0d y %0d last %0b",
                   got.addr, got.x, got.y, got.last);
        end
      end else begin
        want = pending_pixels.pop_front();
        if (got.addr !== want.addr || got.x !== want.x || got.y !== want.y ||
            got.last !== want.last) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("pixel mismatch: want a=%0d x=%0d y=%0d l=%0b, got a=%0d x=%0d y=%0d l=%0b",
                     want.addr, want.x, want.y, want.last,
                     got.addr, got.x, got.y, got.last);
          end
        end
      end
    end
    m_axis_tready <= ($urandom_range(0, 99) >= rx_stall_pct);
  end

  initial begin
    #20_000_000;
    $display("dda_line_rasterizer_core test failed");
    $finish;
  end

  initial begin
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    m_axis_tready = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_data_i = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].set_pitch) begin
        drain_pixels();
        write_pitch(directed_rows[i].pitch);
      end
      send_segment(directed_rows[i].seg, directed_rows[i].fixed, directed_rows[i].pix);
    end

    for (int unsigned phase = 0; phase < NumPhases; phase++) begin
      drain_pixels();
      case (phase)
        0: write_pitch(13'($urandom_range(1, 4096)));
        1: write_pitch(13'd0);
        2: write_pitch(13'd8191);
        3: write_pitch(13'($urandom_range(0, 8191)));
        4: write_pitch(13'd1);
        default: write_pitch(13'd4096);
      endcase
      if (phase < 2) begin
        tx_gap_pct = 24;
        rx_stall_pct = 51;
      end else if (phase < 4) begin
        tx_gap_pct = 51;
        rx_stall_pct = 24;
      end else begin
        tx_gap_pct = 0;
        rx_stall_pct = 0;
      end
      for (int unsigned i = 0; i < ItemsPerPhase; i++) begin
        send_segment(random_segment(), 1'b0, '0);
      end
    end

    drain_pixels();
    repeat (10) @(posedge clk_i);
    if (mismatch_count == 0 && pending_pixels.size() == 0) begin
      $display("dda_line_rasterizer_core test passed");
    end else begin
      $display("dda_line_rasterizer_core test failed");
    end
    $finish;
  end

endmodule
